@@ src/cevq_pkg.sv @@
// ---------------------------------------------------------------------------
// cevq_pkg: shared types and constants of the coalescing event queue
// Request and status codes, take limits and the command passed from the
// front end to the back end.
// ---------------------------------------------------------------------------
package cevq_pkg;

    localparam int KIND_W     = 3;
    localparam int LIMIT_W    = 6;
    localparam int CNT_W      = 6;
    localparam int MAX_TAKE   = 32;
    localparam int CMDQ_DEPTH = 4;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_TAKE  = 2'd1,
        REQ_OPEN  = 2'd2,
        REQ_CLOSE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CLOSED = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // One unit of work for the back end: either a single status result or
    // a take of count events from the read side of the ring.
    typedef struct packed {
        logic               is_take;
        status_t            status;
        logic [CNT_W-1:0]   count;
    } cmd_t;

endpackage

@@ src/cevq_ram.sv @@
// ---------------------------------------------------------------------------
// cevq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data that holds
// while the read enable is low.
// ---------------------------------------------------------------------------
module cevq_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/cevq_cmd_fifo.sv @@
// ---------------------------------------------------------------------------
// cevq_cmd_fifo: command queue between front and back end
// Small register FIFO of commands; lets the front end run ahead while
// results are still draining.
// ---------------------------------------------------------------------------
module cevq_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cevq_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output cevq_pkg::cmd_t  head_cmd,
    output logic            empty,
    output logic            full
);

    localparam int PW = $clog2(cevq_pkg::CMDQ_DEPTH);
    localparam int NW = $clog2(cevq_pkg::CMDQ_DEPTH + 1);

    cevq_pkg::cmd_t  slot_reg [cevq_pkg::CMDQ_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == NW'(cevq_pkg::CMDQ_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(cevq_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(cevq_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/cevq_front.sv @@
// ---------------------------------------------------------------------------
// cevq_front: request front end
// Accept requests, keep the ring bookkeeping, write pushed events to the
// entry store and hand one command per request to the back end.
// ---------------------------------------------------------------------------
module cevq_front #(
    parameter int QUEUE_DEPTH   = 32,
    parameter int PAYLOAD_WIDTH = 48
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic [cevq_pkg::KIND_W-1:0]               move_kind,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  cevq_pkg::req_t                            req_type,
    input  logic [cevq_pkg::KIND_W-1:0]               event_kind,
    input  logic [PAYLOAD_WIDTH-1:0]                  event_payload,
    input  logic [cevq_pkg::LIMIT_W-1:0]              take_limit,
    input  logic                                      cmdq_full,
    output logic                                      cmd_valid,
    output cevq_pkg::cmd_t                            cmd,
    input  logic                                      take_done,
    output logic                                      wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]            wr_addr,
    output logic [PAYLOAD_WIDTH+cevq_pkg::KIND_W-1:0] wr_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = (FW > cevq_pkg::CNT_W) ? FW : cevq_pkg::CNT_W;
    localparam int SW = ((AW > cevq_pkg::CNT_W) ? AW : cevq_pkg::CNT_W) + 1;

    logic [AW-1:0]               head_reg, head_next;
    logic [AW-1:0]               tail_reg, tail_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic                        open_reg, open_next;
    logic [cevq_pkg::KIND_W-1:0] tail_kind_reg, tail_kind_next;
    logic                        busy_reg, busy_next;

    logic                        accept;
    logic [AW-1:0]               tail_prev;
    logic                        coalesce;
    logic                        is_full;
    logic [MW-1:0]               limit_ext, fill_ext, take_min;
    logic [cevq_pkg::CNT_W-1:0]  taken;
    logic [SW-1:0]               head_sum;
    logic [AW-1:0]               head_adv;

    // Pushes must not land on slots a pending take still has to read.
    assign in_ready = !cmdq_full && !busy_reg;
    assign accept   = in_valid && in_ready;

    assign tail_prev = (tail_reg == '0) ? AW'(QUEUE_DEPTH - 1) : tail_reg - 1'b1;
    assign coalesce  = (event_kind == move_kind) && (fill_reg != '0)
                       && (tail_kind_reg == move_kind);
    assign is_full   = (fill_reg == FW'(QUEUE_DEPTH));

    always_comb begin
        limit_ext = MW'(take_limit);
        fill_ext  = MW'(fill_reg);
        take_min  = (limit_ext < fill_ext) ? limit_ext : fill_ext;
        if (take_min > MW'(cevq_pkg::MAX_TAKE)) begin
            take_min = MW'(cevq_pkg::MAX_TAKE);
        end
        taken    = cevq_pkg::CNT_W'(take_min);
        head_sum = SW'(head_reg) + SW'(taken);
        if (head_sum >= SW'(QUEUE_DEPTH)) begin
            head_sum = head_sum - SW'(QUEUE_DEPTH);
        end
        head_adv = AW'(head_sum);
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        open_next      = open_reg;
        tail_kind_next = tail_kind_reg;
        busy_next      = busy_reg;
        cmd_valid      = 1'b0;
        cmd.is_take    = 1'b0;
        cmd.status     = cevq_pkg::ST_OK;
        cmd.count      = '0;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        wr_data        = {event_kind, event_payload};

        if (take_done) begin
            busy_next = 1'b0;
        end

        if (accept) begin
            cmd_valid = 1'b1;
            case (req_type)
                cevq_pkg::REQ_PUSH: begin
                    if (!open_reg) begin
                        cmd.status = cevq_pkg::ST_CLOSED;
                    end else if (coalesce) begin
                        wr_en          = 1'b1;
                        wr_addr        = tail_prev;
                        tail_kind_next = event_kind;
                    end else if (is_full) begin
                        cmd.status = cevq_pkg::ST_FULL;
                    end else begin
                        wr_en          = 1'b1;
                        tail_next      = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : tail_reg + 1'b1;
                        fill_next      = fill_reg + 1'b1;
                        tail_kind_next = event_kind;
                    end
                end
                cevq_pkg::REQ_TAKE: begin
                    if (taken != '0) begin
                        cmd.is_take = 1'b1;
                        cmd.count   = taken;
                        head_next   = head_adv;
                        fill_next   = fill_reg - FW'(taken);
                        busy_next   = 1'b1;
                    end
                end
                cevq_pkg::REQ_OPEN: begin
                    open_next = 1'b1;
                end
                cevq_pkg::REQ_CLOSE: begin
                    open_next = 1'b0;
                    fill_next = '0;
                    tail_next = head_reg;
                end
                default: begin
                    cmd_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            open_reg      <= 1'b0;
            tail_kind_reg <= '0;
            busy_reg      <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            open_reg      <= open_next;
            tail_kind_reg <= tail_kind_next;
            busy_reg      <= busy_next;
        end
    end

endmodule

@@ src/cevq_back.sv @@
// ---------------------------------------------------------------------------
// cevq_back: result back end
// Execute commands: emit single status results, or read taken events from
// the entry store one per cycle unless the output stalls, sent out in order.
// ---------------------------------------------------------------------------
module cevq_back #(
    parameter int QUEUE_DEPTH   = 32,
    parameter int PAYLOAD_WIDTH = 48
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cmdq_empty,
    input  cevq_pkg::cmd_t                            cmdq_head,
    output logic                                      cmdq_pop,
    output logic                                      take_done,
    output logic                                      rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]            rd_addr,
    input  logic [PAYLOAD_WIDTH+cevq_pkg::KIND_W-1:0] rd_data,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output cevq_pkg::status_t                         out_status,
    output logic                                      out_event_valid,
    output logic [cevq_pkg::KIND_W-1:0]               out_kind,
    output logic [PAYLOAD_WIDTH-1:0]                  out_payload,
    output logic                                      out_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    // current command
    logic                       cur_valid_reg, cur_valid_next;
    logic                       cur_is_take_reg;
    cevq_pkg::status_t          cur_status_reg;
    logic [cevq_pkg::CNT_W-1:0] cur_left_reg, cur_left_next;
    logic [AW-1:0]              rd_ptr_reg, rd_ptr_next;

    // read stage
    logic                       s1_valid_reg, s1_valid_next;
    cevq_pkg::status_t          s1_status_reg;
    logic                       s1_event_reg;
    logic                       s1_last_reg;

    // output register
    logic                       o_valid_reg, o_valid_next;
    cevq_pkg::status_t          o_status_reg;
    logic                       o_event_reg;
    logic [cevq_pkg::KIND_W-1:0] o_kind_reg;
    logic [PAYLOAD_WIDTH-1:0]   o_payload_reg;
    logic                       o_last_reg;

    logic out_load, s1_free, issue, cur_last, cur_done, load_cmd;

    assign out_load = s1_valid_reg && (!o_valid_reg || out_ready);
    assign s1_free  = !s1_valid_reg || out_load;
    assign issue    = cur_valid_reg && s1_free;
    assign cur_last = !cur_is_take_reg || (cur_left_reg == cevq_pkg::CNT_W'(1));
    assign cur_done = issue && cur_last;
    assign load_cmd = (!cur_valid_reg || cur_done) && !cmdq_empty;

    assign cmdq_pop  = load_cmd;
    assign take_done = issue && cur_is_take_reg && cur_last;
    assign rd_en     = issue && cur_is_take_reg;
    assign rd_addr   = rd_ptr_reg;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_left_next  = cur_left_reg;
        rd_ptr_next    = rd_ptr_reg;
        if (issue) begin
            cur_left_next = cur_left_reg - 1'b1;
            if (cur_is_take_reg) begin
                rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
            end
            if (cur_last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (load_cmd) begin
            cur_valid_next = 1'b1;
            cur_left_next  = cmdq_head.count;
        end

        s1_valid_next = issue ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
        o_valid_next  = out_load ? 1'b1 : (out_ready ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            o_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_valid_reg  <= s1_valid_next;
            o_valid_reg   <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_left_reg <= cur_left_next;
        if (load_cmd) begin
            cur_is_take_reg <= cmdq_head.is_take;
            cur_status_reg  <= cmdq_head.status;
        end
        if (issue) begin
            s1_status_reg <= cur_is_take_reg ? cevq_pkg::ST_OK : cur_status_reg;
            s1_event_reg  <= cur_is_take_reg;
            s1_last_reg   <= cur_last;
        end
        if (out_load) begin
            o_status_reg  <= s1_status_reg;
            o_event_reg   <= s1_event_reg;
            o_last_reg    <= s1_last_reg;
            o_kind_reg    <= s1_event_reg ? rd_data[PAYLOAD_WIDTH +: cevq_pkg::KIND_W] : '0;
            o_payload_reg <= s1_event_reg ? rd_data[PAYLOAD_WIDTH-1:0] : '0;
        end
    end

    assign out_valid       = o_valid_reg;
    assign out_status      = o_status_reg;
    assign out_event_valid = o_event_reg;
    assign out_kind        = o_kind_reg;
    assign out_payload     = o_payload_reg;
    assign out_last        = o_last_reg;

endmodule

@@ src/coalescing_event_queue.sv @@
// ---------------------------------------------------------------------------
// coalescing_event_queue: bounded event FIFO with tail move coalescing
// Ring-buffer event queue that can be opened and closed. A move event that
// follows a queued move replaces it; take requests drain the oldest events.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Carries
// s_axis    in   s_axis_tvalid/tready    requests: push, take, open, close
// m_axis    out  m_axis_tvalid/tready    results: status or one taken event
// cfg       in   cfg_wr_en               move_kind register, no read-back
//
// Push, open and close each give one result transfer. A take of N events
// gives N transfers, one per cycle unless the output stalls, read through
// the entry store's single read port; a take of nothing gives one transfer.
// While a take is still reading, new requests are held off (tready low) so
// later pushes cannot overwrite unread slots. Reset (aresetn low,
// synchronous) closes and empties the queue; the entry store needs no
// clearing pass. Under an output stall seven push, open or close requests
// are taken in (output and read stages, the current command and the
// four-entry command queue) before tready drops.
// ---------------------------------------------------------------------------
module coalescing_event_queue #(
    parameter int QUEUE_DEPTH   = 32,
    parameter int PAYLOAD_WIDTH = 48
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // configuration: move_kind
    input  logic                                    cfg_wr_en,
    input  logic [2:0]                              cfg_wr_data,

    // request channel
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata from bit 0: event_kind[3], event_payload[PAYLOAD_WIDTH], take_limit[6]
    input  logic [((PAYLOAD_WIDTH+16)/8)*8-1:0]     s_axis_tdata,
    // tuser from bit 0: req_type[2]
    input  logic [1:0]                              s_axis_tuser,

    // result channel
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata from bit 0: out_kind[3], out_payload[PAYLOAD_WIDTH], zero fill
    output logic [((PAYLOAD_WIDTH+10)/8)*8-1:0]     m_axis_tdata,
    // tuser from bit 0: status[2], event_valid[1]
    output logic [2:0]                              m_axis_tuser,
    output logic                                    m_axis_tlast
);

    localparam int KW    = cevq_pkg::KIND_W;
    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int EW    = PAYLOAD_WIDTH + KW;
    localparam int OUT_W = ((PAYLOAD_WIDTH + 10) / 8) * 8;

    logic [KW-1:0]               move_kind_reg;

    cevq_pkg::cmd_t              cmd, cmdq_head;
    logic                        cmd_valid, cmdq_pop, cmdq_empty, cmdq_full;
    logic                        take_done;
    logic                        wr_en, rd_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [EW-1:0]               wr_data, rd_data;

    cevq_pkg::status_t           res_status;
    logic                        res_event;
    logic [KW-1:0]               res_kind;
    logic [PAYLOAD_WIDTH-1:0]    res_payload;

    // Take the coalescing kind; the user must write it only while the queue is idle, the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_kind_reg <= '0;
        end else if (cfg_wr_en) begin
            move_kind_reg <= cfg_wr_data;
        end
    end

    cevq_front #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .move_kind     (move_kind_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .req_type      (cevq_pkg::req_t'(s_axis_tuser)),
        .event_kind    (s_axis_tdata[KW-1:0]),
        .event_payload (s_axis_tdata[KW +: PAYLOAD_WIDTH]),
        .take_limit    (s_axis_tdata[EW +: cevq_pkg::LIMIT_W]),
        .cmdq_full     (cmdq_full),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .take_done     (take_done),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    cevq_cmd_fifo u_cmdq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_valid),
        .push_cmd (cmd),
        .pop      (cmdq_pop),
        .head_cmd (cmdq_head),
        .empty    (cmdq_empty),
        .full     (cmdq_full)
    );

    // Entry store: kind in the top bits, payload below.
    cevq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cevq_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmdq_empty      (cmdq_empty),
        .cmdq_head       (cmdq_head),
        .cmdq_pop        (cmdq_pop),
        .take_done       (take_done),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_status      (res_status),
        .out_event_valid (res_event),
        .out_kind        (res_kind),
        .out_payload     (res_payload),
        .out_last        (m_axis_tlast)
    );

    // Pack the result transfer; pad tdata with zeros to whole bytes.
    assign m_axis_tdata = OUT_W'({res_payload, res_kind});
    assign m_axis_tuser = {res_event, res_status};

endmodule

@@ sim/cevq_tb_pkg.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cevq_tb_pkg: result prediction and checking for the event queue bench
// Keeps a private copy of the ring, fill level, open flag and move kind.
// Works out the results that each accepted request must give, then matches
// every result transfer against the oldest one still owed.
// ---------------------------------------------------------------------------
package cevq_tb_pkg;

    import cevq_pkg::*;

    localparam int QDEPTH    = 32;
    localparam int PAYLOAD_W = 48;

    typedef struct packed {
        status_t                status;
        logic                   event_valid;
        logic [KIND_W-1:0]      kind;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   last;
    } queue_result_t;

    class event_queue_scoreboard;

        logic [KIND_W-1:0]      slot_kind [QDEPTH];
        logic [PAYLOAD_W-1:0]   slot_payload [QDEPTH];
        int unsigned            head;
        int unsigned            fill;
        bit                     opened;
        logic [KIND_W-1:0]      move_kind;
        queue_result_t          owed_results [$];
        int unsigned            errors;

        function new();
            head      = 0;
            fill      = 0;
            opened    = 1'b0;
            move_kind = '0;
            errors    = 0;
        endfunction

        function void set_move_kind(logic [KIND_W-1:0] value);
            move_kind = value;
        endfunction

        function int unsigned outstanding();
            return owed_results.size();
        endfunction

        function void owe(status_t status, logic valid, logic [KIND_W-1:0] kind,
                          logic [PAYLOAD_W-1:0] payload, logic last);
            queue_result_t r;
            r.status      = status;
            r.event_valid = valid;
            r.kind        = kind;
            r.payload     = payload;
            r.last        = last;
            owed_results.push_back(r);
        endfunction

        // Update the ring copy for one accepted request and owe its results.
        function void apply_request(req_t req, logic [KIND_W-1:0] kind,
                                    logic [PAYLOAD_W-1:0] payload,
                                    logic [LIMIT_W-1:0] limit);
            int unsigned tail;
            int unsigned taken;
            int unsigned idx;
            case (req)
                REQ_PUSH: begin
                    tail = (head + fill + QDEPTH - 1) % QDEPTH;
                    if (!opened) begin
                        owe(ST_CLOSED, 1'b0, '0, '0, 1'b1);
                    end else if (kind == move_kind && fill > 0 &&
                                 slot_kind[tail] == move_kind) begin
                        // overwrite the queued move in place, even when full
                        slot_kind[tail]    = kind;
                        slot_payload[tail] = payload;
                        owe(ST_OK, 1'b0, '0, '0, 1'b1);
                    end else if (fill >= QDEPTH) begin
                        owe(ST_FULL, 1'b0, '0, '0, 1'b1);
                    end else begin
                        idx               = (head + fill) % QDEPTH;
                        slot_kind[idx]    = kind;
                        slot_payload[idx] = payload;
                        fill++;
                        owe(ST_OK, 1'b0, '0, '0, 1'b1);
                    end
                end
                REQ_TAKE: begin
                    taken = limit;
                    if (taken > fill)
                        taken = fill;
                    if (taken > MAX_TAKE)
                        taken = MAX_TAKE;
                    if (taken == 0) begin
                        owe(ST_OK, 1'b0, '0, '0, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < taken; i++) begin
                            idx = (head + i) % QDEPTH;
                            owe(ST_OK, 1'b1, slot_kind[idx], slot_payload[idx],
                                i + 1 == taken);
                        end
                        head = (head + taken) % QDEPTH;
                        fill = fill - taken;
                    end
                end
                REQ_OPEN: begin
                    opened = 1'b1;
                    owe(ST_OK, 1'b0, '0, '0, 1'b1);
                end
                default: begin
                    opened = 1'b0;
                    fill   = 0;
                    owe(ST_OK, 1'b0, '0, '0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(status_t status, logic valid, logic [KIND_W-1:0] kind,
                                   logic [PAYLOAD_W-1:0] payload, logic last);
            queue_result_t want;
            if (owed_results.size() == 0) begin
                $error("result transfer with nothing owed: status %0d valid %0b",
                       status, valid);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (valid !== want.event_valid) begin
                $error("event_valid: expected %0b, got %0b", want.event_valid, valid);
                errors++;
            end
            if (kind !== want.kind) begin
                $error("out_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (payload !== want.payload) begin
                $error("out_payload: expected %h, got %h", want.payload, payload);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

    endclass

endpackage

@@ sim/tb_coalescing_event_queue.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_coalescing_event_queue: self-checking bench for the event queue
// Drives push, take, open and close requests with random gaps on both
// channels, changes the move kind between phases and checks every result
// transfer against a predicted copy of the queue.
// ---------------------------------------------------------------------------
module tb_coalescing_event_queue;

    import cevq_pkg::*;
    import cevq_tb_pkg::*;

    localparam int IN_W         = ((PAYLOAD_W + 16) / 8) * 8;
    localparam int OUT_W        = ((PAYLOAD_W + 10) / 8) * 8;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 270;
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int SETTLE       = 8;       // idle cycles before a register write
    localparam int TAIL_CYCLES  = 24;      // quiet time at the end of the run
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int FILL_PHASE   = 2;       // phase that always runs the fill traffic

    localparam logic [PAYLOAD_W-1:0] ONES = '1;
    localparam logic [PAYLOAD_W-1:0] ALT_A = 48'hAAAA_AAAA_AAAA;
    localparam logic [PAYLOAD_W-1:0] ALT_5 = 48'h5555_5555_5555;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [KIND_W-1:0]     cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    event_queue_scoreboard sb;

    bit s_busy;            // sender idles between requests
    bit m_busy;            // receiver stalls between results
    bit hold_req;          // ask the receiver for one long hold-off
    int sent_count;
    int cycle_count = 0;

    coalescing_event_queue #(
        .QUEUE_DEPTH   (QDEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_W)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b0;
        #(HALF_PERIOD);
        aclk = 1'b1;
        #(HALF_PERIOD);
    end

    // Watchdog: end the run if the bench hangs on a handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONES;
            default: return w[PAYLOAD_W-1:0];
        endcase
    endfunction

    // Any kind except the current move kind.
    function automatic logic [KIND_W-1:0] other_kind(logic [KIND_W-1:0] mk);
        logic [KIND_W-1:0] k;
        k = KIND_W'($urandom_range(0, 6));
        if (k >= mk)
            k = k + 1'b1;
        return k;
    endfunction

    // Mostly small limits, so the queue holds something between takes.
    function automatic logic [LIMIT_W-1:0] rand_limit();
        if ($urandom_range(0, 3) == 0)
            return LIMIT_W'($urandom_range(0, MAX_TAKE));
        return LIMIT_W'($urandom_range(0, 4));
    endfunction

    function automatic int draw_gap(bit busy);
        return busy ? $urandom_range(0, 19) : 0;
    endfunction

    // Offer one request from a falling edge and hold it until the transfer.
    // Returns on the falling edge after the transfer with tvalid still high,
    // so a back-to-back request simply replaces the data.
    task automatic send_request(req_t req, logic [KIND_W-1:0] kind,
                                logic [PAYLOAD_W-1:0] payload, logic [LIMIT_W-1:0] limit);
        int gap;
        gap = draw_gap(s_busy);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{(IN_W - KIND_W - PAYLOAD_W - LIMIT_W){1'b0}},
                          limit, payload, kind};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        sb.apply_request(req, kind, payload, limit);
        sent_count++;
        @(negedge aclk);
    endtask

    // Drop tvalid and wait until every owed result has arrived, then let
    // the back end settle before anything touches the register.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_move_kind(logic [KIND_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_move_kind(value);
    endtask

    // Receiver: stall a random number of cycles per result, once honour a
    // long hold-off, and check each result transfer at the rising edge.
    initial begin : result_side
        int gap;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = draw_gap(m_busy);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid)
                @(posedge aclk);
            sb.check_result(status_t'(m_axis_tuser[1:0]), m_axis_tuser[2],
                            m_axis_tdata[KIND_W-1:0],
                            m_axis_tdata[KIND_W+PAYLOAD_W-1:KIND_W], m_axis_tlast);
        end
    end

    initial begin : request_side
        int n;
        int pick;
        int phase_no;
        bit held;
        logic [KIND_W-1:0] mk;

        sb            = new();
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PUSH;
        s_busy        = 1'b0;
        m_busy        = 1'b0;
        hold_req      = 1'b0;
        sent_count    = 0;
        held          = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, move kind still at its reset value of zero.
        send_request(REQ_PUSH,  3'd5, ONES, '0);             // push while closed
        send_request(REQ_TAKE,  '0, '0, LIMIT_W'(MAX_TAKE)); // take from empty, closed
        send_request(REQ_CLOSE, '0, '0, '0);                 // close while closed
        send_request(REQ_OPEN,  '0, '0, '0);
        send_request(REQ_OPEN,  '0, '0, '0);                 // open while open
        send_request(REQ_PUSH,  3'd0, '0, '0);
        send_request(REQ_PUSH,  3'd0, ONES, '0);             // coalesce onto the move
        send_request(REQ_PUSH,  3'd7, ALT_A, ONES[LIMIT_W-1:0]);
        send_request(REQ_TAKE,  '0, '0, '0);                 // limit of zero
        send_request(REQ_TAKE,  3'd7, ALT_5, 6'd1);
        send_request(REQ_TAKE,  '0, '0, LIMIT_W'(MAX_TAKE)); // limit above fill
        send_request(REQ_TAKE,  '0, '0, 6'd3);               // take from empty, open

        write_move_kind(3'd7);
        send_request(REQ_PUSH,  3'd7, ALT_5, '0);
        send_request(REQ_PUSH,  3'd7, ALT_A, '0);            // coalesce
        send_request(REQ_PUSH,  3'd0, ONES, '0);
        send_request(REQ_PUSH,  3'd7, '0, '0);               // tail not a move: append
        send_request(REQ_CLOSE, '0, '0, '0);                 // close empties
        send_request(REQ_PUSH,  3'd3, ALT_5, '0);
        send_request(REQ_TAKE,  '0, '0, LIMIT_W'(MAX_TAKE));
        send_request(REQ_OPEN,  '0, '0, '0);
        send_request(REQ_PUSH,  3'd6, ALT_A, '0);
        send_request(REQ_TAKE,  '0, '0, LIMIT_W'(MAX_TAKE));

        // Random part in phases: idle pattern, register value and kind of
        // traffic change from phase to phase.
        phase_no   = 0;
        while (sent_count < RANDOM_ITEMS) begin
            if (phase_no < 2 || $urandom_range(0, 2) == 0) begin
                case (phase_no)
                    0:       mk = 3'd0;
                    1:       mk = KIND_W'($urandom_range(1, 6));
                    default: mk = KIND_W'($urandom_range(0, 7));
                endcase
                write_move_kind(mk);
            end
            s_busy = ($urandom_range(0, 1) == 1);
            m_busy = ($urandom_range(0, 1) == 1);
            pick   = (phase_no == FILL_PHASE) ? 6 : $urandom_range(0, 9);

            if (pick < 6) begin
                // Session: mostly open traffic with moves bunched together.
                if ($urandom_range(0, 3) != 0)
                    send_request(REQ_OPEN, '0, '0, '0);
                n = $urandom_range(8, 20);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        send_request(REQ_PUSH,
                                     ($urandom_range(0, 9) < 4) ? sb.move_kind
                                                                : other_kind(sb.move_kind),
                                     rand_payload(), rand_limit());
                    else if (pick < 85)
                        send_request(REQ_TAKE, KIND_W'($urandom), rand_payload(),
                                     rand_limit());
                    else if (pick < 93)
                        send_request(REQ_OPEN, '0, '0, '0);
                    else
                        send_request(REQ_CLOSE, '0, '0, '0);
                end
            end else if (pick < 8) begin
                // Fill to the brim, try the full cases, then drain.
                send_request(REQ_OPEN, '0, '0, '0);
                if (!held) begin
                    held     = 1'b1;
                    hold_req = 1'b1;   // stall results while requests pour in
                    s_busy   = 1'b0;
                end
                n = $urandom_range(32, 40);
                repeat (n)
                    send_request(REQ_PUSH,
                                 ($urandom_range(0, 3) == 0) ? sb.move_kind
                                                             : other_kind(sb.move_kind),
                                 rand_payload(), '0);
                send_request(REQ_PUSH, sb.move_kind, rand_payload(), '0);
                send_request(REQ_PUSH, sb.move_kind, rand_payload(), '0);
                send_request(REQ_PUSH, other_kind(sb.move_kind), rand_payload(), '0);
                send_request(REQ_TAKE, '0, '0,
                             ($urandom_range(0, 1) == 1) ? LIMIT_W'(MAX_TAKE)
                                                         : LIMIT_W'($urandom_range(1, 32)));
                while (sb.fill != 0)
                    send_request(REQ_TAKE, '0, '0, LIMIT_W'($urandom_range(1, 32)));
            end else begin
                // Noise: every field at random.
                n = $urandom_range(5, 10);
                repeat (n)
                    send_request(req_t'($urandom_range(0, 3)), KIND_W'($urandom),
                                 rand_payload(), LIMIT_W'($urandom_range(0, MAX_TAKE)));
            end
            phase_no++;
        end

        // Let everything owed come out, then watch for strays.
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
